[rtl/tesv_pkg.sv]
// Shared types and constants of the text encoding stream validator.
package tesv_pkg;

    // Width of the line, column and offset counters.
    localparam int COUNT_WIDTH = 32;
    localparam int OUT_WIDTH   = 32;

    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [OUT_WIDTH-1:0]   t_out_word;

    localparam t_count CNT_MAX   = '1;
    localparam t_count LINE_INIT = COUNT_WIDTH'(1);

    // Encoding selector codes.
    localparam logic [1:0] ENC_ASCII = 2'd0;
    localparam logic [1:0] ENC_GBK   = 2'd1;
    localparam logic [1:0] ENC_UTF8  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_IDX_ENCODING   = 1'b0;
    localparam logic CFG_IDX_THREE_ONLY = 1'b1;

    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    // What one byte does to the character tracker.
    typedef enum logic [2:0] {
        ACT_IDLE,
        ACT_OPEN,
        ACT_ADVANCE,
        ACT_ACCEPT,
        ACT_FAIL
    } t_char_act;

    // Per-character state seen by the checker.
    typedef struct packed {
        logic       stopped;
        logic [2:0] needed;
        logic [2:0] seen;
        logic [7:0] lead;
    } t_char_state;

    // Decision of the checker for one byte.
    typedef struct packed {
        t_char_act  act;
        logic [2:0] len;
        logic       newline;
        logic [7:0] first;
    } t_char_step;

    // Figures reported at the end of a stream.
    typedef struct packed {
        logic   passed;
        t_count line;
        t_count col;
        t_count offset;
    } t_result;

endpackage

[rtl/tesv_byte_if.sv]
// Stream interfaces for input bytes and end-of-stream results.
interface tesv_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface tesv_result_if;
    logic        valid;
    logic        ready;
    logic        passed;
    logic [31:0] stop_line;
    logic [31:0] stop_col;
    logic [31:0] stop_offset;

    modport source (output valid, output passed, output stop_line, output stop_col,
                    output stop_offset, input ready);
    modport sink   (input valid, input passed, input stop_line, input stop_col,
                    input stop_offset, output ready);
endinterface

[rtl/tesv_char_check.sv]
// Combinational character check: decides what one byte does to the open character.
module tesv_char_check (
    input  tesv_pkg::t_char_state i_state,
    input  logic [7:0]            i_byte,
    input  logic [1:0]            i_enc,
    input  logic                  i_three_only,
    output tesv_pkg::t_char_step  o_step
);

    localparam logic [1:0] ENC_GBK_SEL  = tesv_pkg::ENC_GBK;
    localparam logic [1:0] ENC_UTF8_SEL = tesv_pkg::ENC_UTF8;

    // GBK lead and trail byte ranges.
    function automatic logic gbk_pair(input logic [7:0] a, input logic [7:0] b);
        logic t_hi;
        logic t_lo;
        begin
            t_hi = (b >= 8'hA1) && (b <= 8'hFE);
            t_lo = (b >= 8'h40) && (b != 8'h7F);
            gbk_pair = ((a >= 8'hA1) && (a <= 8'hA9) && t_hi) ||
                       ((a >= 8'hB0) && (a <= 8'hF7) && t_hi) ||
                       ((a >= 8'h81) && (a <= 8'hA0) && t_lo && (b <= 8'hFE)) ||
                       ((a >= 8'hAA) && (a <= 8'hFE) && t_lo && (b <= 8'hA0)) ||
                       ((a >= 8'hA8) && (a <= 8'hA9) && t_lo && (b <= 8'hA0));
        end
    endfunction

    // Count of leading ones of a byte, 0 to 8.
    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] cnt;
        logic       run;
        begin
            cnt = 4'd0;
            run = 1'b1;
            for (int k = 7; k >= 0; k--) begin
                run = run & b[k];
                cnt = cnt + {3'd0, run};
            end
            lead_ones = cnt;
        end
    endfunction

    logic [3:0] ones;
    logic       utf8_lead_ok;
    logic       trail_ok;
    logic [2:0] seen_inc;

    assign ones         = lead_ones(i_byte);
    assign utf8_lead_ok = (ones >= 4'd2) && (ones <= 4'd6) && (!i_three_only || ones == 4'd3);
    assign seen_inc     = i_state.seen + 3'd1;

    // Trail byte check under the current selector.
    always_comb begin
        case (i_enc)
            ENC_GBK_SEL: trail_ok = gbk_pair(i_state.lead, i_byte);
            ENC_UTF8_SEL: trail_ok = (i_byte[7:6] == 2'b10);
            default: trail_ok = 1'b0;
        endcase
    end

    // Action for this byte.
    always_comb begin
        o_step.act     = tesv_pkg::ACT_IDLE;
        o_step.len     = 3'd1;
        o_step.newline = 1'b0;
        o_step.first   = i_byte;
        if (i_state.stopped) begin
            o_step.act = tesv_pkg::ACT_IDLE;
        end else if (i_state.needed == 3'd0) begin
            if (!i_byte[7]) begin
                o_step.act     = tesv_pkg::ACT_ACCEPT;
                o_step.newline = (i_byte == tesv_pkg::NEWLINE_CHAR);
            end else if (i_enc == tesv_pkg::ENC_GBK) begin
                o_step.act = tesv_pkg::ACT_OPEN;
                o_step.len = 3'd2;
            end else if (i_enc == tesv_pkg::ENC_UTF8 && utf8_lead_ok) begin
                o_step.act = tesv_pkg::ACT_OPEN;
                o_step.len = ones[2:0];
            end else begin
                o_step.act = tesv_pkg::ACT_FAIL;
            end
        end else if (!trail_ok) begin
            o_step.act = tesv_pkg::ACT_FAIL;
        end else if (seen_inc >= i_state.needed) begin
            o_step.act     = tesv_pkg::ACT_ACCEPT;
            o_step.len     = i_state.needed;
            o_step.newline = (i_state.lead == tesv_pkg::NEWLINE_CHAR);
            o_step.first   = i_state.lead;
        end else begin
            o_step.act = tesv_pkg::ACT_ADVANCE;
        end
    end

endmodule

[rtl/tesv_tracker.sv]
// Character state and saturating line, column and offset counters.
module tesv_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step_en,
    input  logic                  i_eos,
    input  tesv_pkg::t_char_step  i_step,
    output tesv_pkg::t_char_state o_state,
    output tesv_pkg::t_result     o_result
);

    localparam int SumW = tesv_pkg::COUNT_WIDTH + 1;

    logic             r_stopped;
    logic [2:0]       r_needed;
    logic [2:0]       r_seen;
    logic [7:0]       r_lead;
    tesv_pkg::t_count r_line;
    tesv_pkg::t_count r_col;
    tesv_pkg::t_count r_offset;

    logic             n_stopped;
    logic [2:0]       n_needed;
    logic [2:0]       n_seen;
    logic [7:0]       n_lead;
    tesv_pkg::t_count n_line;
    tesv_pkg::t_count n_col;
    tesv_pkg::t_count n_offset;

    logic             open_char;
    logic             tail_fail;
    logic             col_inc;
    logic [SumW-1:0]  off_sum;
    tesv_pkg::t_count col_sat;
    tesv_pkg::t_count line_sat;
    tesv_pkg::t_count off_sat;

    assign o_state = '{stopped: r_stopped, needed: r_needed, seen: r_seen, lead: r_lead};

    // A character still open on the last beat fails as truncated.
    assign open_char = (i_step.act == tesv_pkg::ACT_OPEN) || (i_step.act == tesv_pkg::ACT_ADVANCE);
    assign tail_fail = i_eos && open_char;
    assign col_inc   = (i_step.act == tesv_pkg::ACT_FAIL) || tail_fail ||
                       (i_step.act == tesv_pkg::ACT_ACCEPT);

    // Saturating increments.
    assign col_sat  = (r_col == tesv_pkg::CNT_MAX) ? r_col : r_col + tesv_pkg::COUNT_WIDTH'(1);
    assign line_sat = (r_line == tesv_pkg::CNT_MAX) ? r_line : r_line + tesv_pkg::COUNT_WIDTH'(1);
    assign off_sum  = {1'b0, r_offset} + SumW'(i_step.len);
    assign off_sat  = off_sum[SumW-1] ? tesv_pkg::CNT_MAX : off_sum[SumW-2:0];

    // Next character state and counters for this beat.
    always_comb begin
        n_stopped = r_stopped;
        n_needed  = r_needed;
        n_seen    = r_seen;
        n_lead    = r_lead;
        n_line    = r_line;
        n_col     = col_inc ? col_sat : r_col;
        n_offset  = r_offset;
        case (i_step.act)
            tesv_pkg::ACT_OPEN: begin
                n_lead   = i_step.first;
                n_needed = i_step.len;
                n_seen   = 3'd1;
            end
            tesv_pkg::ACT_ADVANCE: begin
                n_seen = r_seen + 3'd1;
            end
            tesv_pkg::ACT_ACCEPT: begin
                n_offset = off_sat;
                n_needed = 3'd0;
                n_seen   = 3'd0;
                if (i_step.newline) begin
                    n_line = line_sat;
                    n_col  = '0;
                end
            end
            tesv_pkg::ACT_FAIL: begin
                n_stopped = 1'b1;
                n_needed  = 3'd0;
                n_seen    = 3'd0;
            end
            default: begin
            end
        endcase
        if (tail_fail) begin
            n_stopped = 1'b1;
        end
    end

    // Figures for the end-of-stream beat.
    assign o_result = '{passed: !n_stopped, line: n_line, col: n_col, offset: n_offset};

    // State registers; the last beat of a stream returns them to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step_en && i_eos)) begin
            r_stopped <= 1'b0;
            r_needed  <= 3'd0;
            r_seen    <= 3'd0;
            r_lead    <= 8'd0;
            r_line    <= tesv_pkg::LINE_INIT;
            r_col     <= '0;
            r_offset  <= '0;
        end else if (i_step_en) begin
            r_stopped <= n_stopped;
            r_needed  <= n_needed;
            r_seen    <= n_seen;
            r_lead    <= n_lead;
            r_line    <= n_line;
            r_col     <= n_col;
            r_offset  <= n_offset;
        end
    end

endmodule

[rtl/text_encoding_stream_validator.sv]
// Top level of the text encoding stream validator: input register, checker, result register.
//
// The validator checks a byte stream as ASCII, GBK or UTF-8 and takes one byte beat per
// clock cycle. A beat is held in the input register, checked against the open character
// and counted; the beat marked end_of_stream, when it leaves the input register, loads one
// result into the result register, which offers it. The only stall comes from the result
// side: an end-of-stream beat waits in the input register while an earlier result is still
// unread, and input beats behind it wait too. Line, column and offset counters saturate;
// after a bad or truncated character the block ignores bytes until the end of the stream.
// Configuration writes take effect on the next beat and are meant for idle periods.
module text_encoding_stream_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [1:0]  i_cfg_data,
    tesv_byte_if.sink   i_in,
    tesv_result_if.source o_res
);

    logic [1:0]            r_enc;
    logic                  r_three_only;
    logic                  r_in_valid;
    logic [7:0]            r_byte;
    logic                  r_eos;
    logic                  r_out_valid;
    logic                  r_passed;
    tesv_pkg::t_out_word   r_line;
    tesv_pkg::t_out_word   r_col;
    tesv_pkg::t_out_word   r_offset;

    logic                  consume;
    tesv_pkg::t_char_state state;
    tesv_pkg::t_char_step  step;
    tesv_pkg::t_result     result;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc        <= tesv_pkg::ENC_UTF8;
            r_three_only <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tesv_pkg::CFG_IDX_ENCODING:   r_enc        <= i_cfg_data;
                tesv_pkg::CFG_IDX_THREE_ONLY: r_three_only <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The held beat moves on unless it must produce a result that has nowhere to go.
    assign consume    = r_in_valid && (!r_eos || !r_out_valid || o_res.ready);
    assign i_in.ready = !r_in_valid || consume;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_eos  <= i_in.end_of_stream;
        end
    end

    tesv_char_check u_check (
        .i_state      (state),
        .i_byte       (r_byte),
        .i_enc        (r_enc),
        .i_three_only (r_three_only),
        .o_step       (step)
    );

    tesv_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step_en (consume),
        .i_eos     (r_eos),
        .i_step    (step),
        .o_state   (state),
        .o_result  (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_eos) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_eos) begin
            r_passed <= result.passed;
            r_line   <= tesv_pkg::OUT_WIDTH'(result.line);
            r_col    <= tesv_pkg::OUT_WIDTH'(result.col);
            r_offset <= tesv_pkg::OUT_WIDTH'(result.offset);
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.passed      = r_passed;
    assign o_res.stop_line   = r_line;
    assign o_res.stop_col    = r_col;
    assign o_res.stop_offset = r_offset;

endmodule

[bench/tb.sv]
// Self-checking testbench of the text encoding stream validator with its own byte-level predictor.
module tb;

    localparam int         IDLE_PCT      = 27;
    localparam int         DRAIN_CYCLES  = 6;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         BEAT_TARGET   = 600;
    localparam int         REPORT_TARGET = 40;
    localparam int         MAX_SHOWN     = 10;
    // The selector value that has no checker of its own.
    localparam logic [1:0] ENC_SPARE     = 2'd3;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [1:0] cfg_data;

    tesv_byte_if   byte_ch ();
    tesv_result_if report_ch ();

    text_encoding_stream_validator i_dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in      (byte_ch),
        .o_res     (report_ch)
    );

    // Predictor copy of the registers and of the per-stream state.
    logic [1:0]            enc_sel;
    logic                  three_only;
    tesv_pkg::t_char_state chr;
    tesv_pkg::t_count      line_cnt;
    tesv_pkg::t_count      col_cnt;
    tesv_pkg::t_count      byte_offs;

    tesv_pkg::t_result     pending_reports[$];
    logic [7:0]            stream_bytes[$];

    int unsigned sent_beats;
    int unsigned checked_beats;
    int unsigned reports_made;
    int unsigned reports_seen;
    int unsigned reports_clean;
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          steady_mode;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Counter addition that sticks at the all-ones value.
    function automatic tesv_pkg::t_count sat_add(tesv_pkg::t_count a, tesv_pkg::t_count b);
        logic [tesv_pkg::COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return (sum > {1'b0, tesv_pkg::CNT_MAX}) ? tesv_pkg::CNT_MAX :
                                                    sum[tesv_pkg::COUNT_WIDTH-1:0];
    endfunction

    function automatic bit gbk_pair_ok(logic [7:0] a, logic [7:0] b);
        return (a >= 8'hA1 && a <= 8'hA9 && b >= 8'hA1 && b <= 8'hFE) ||
               (a >= 8'hB0 && a <= 8'hF7 && b >= 8'hA1 && b <= 8'hFE) ||
               (a >= 8'h81 && a <= 8'hA0 && b >= 8'h40 && b <= 8'hFE && b != 8'h7F) ||
               (a >= 8'hAA && a <= 8'hFE && b >= 8'h40 && b <= 8'hA0 && b != 8'h7F) ||
               (a >= 8'hA8 && a <= 8'hA9 && b >= 8'h40 && b <= 8'hA0 && b != 8'h7F);
    endfunction

    function automatic void clear_stream();
        chr       = '0;
        line_cnt  = tesv_pkg::LINE_INIT;
        col_cnt   = '0;
        byte_offs = '0;
    endfunction

    // A bad character is counted in the column and freezes the stream.
    function automatic void fail_char();
        col_cnt     = sat_add(col_cnt, tesv_pkg::t_count'(1));
        chr.stopped = 1'b1;
        chr.needed  = '0;
        chr.seen    = '0;
    endfunction

    function automatic void accept_char(logic [2:0] len, logic [7:0] first);
        col_cnt   = sat_add(col_cnt, tesv_pkg::t_count'(1));
        byte_offs = sat_add(byte_offs, tesv_pkg::t_count'(len));
        if (first == tesv_pkg::NEWLINE_CHAR) begin
            line_cnt = sat_add(line_cnt, tesv_pkg::t_count'(1));
            col_cnt  = '0;
        end
        chr.needed = '0;
        chr.seen   = '0;
    endfunction

    // First byte of a character: ASCII completes it, a lead byte the selector takes opens it, any other byte fails it.
    function automatic void open_char(logic [7:0] b);
        int ones;
        ones = 0;
        if (b < 8'h80) begin
            accept_char(3'd1, b);
        end else if (enc_sel == tesv_pkg::ENC_GBK) begin
            chr.lead   = b;
            chr.needed = 3'd2;
            chr.seen   = 3'd1;
        end else if (enc_sel == tesv_pkg::ENC_UTF8) begin
            while (ones < 8 && b[7 - ones]) ones++;
            if (ones < 2 || ones > 6 || (three_only && ones != 3)) begin
                fail_char();
            end else begin
                chr.lead   = b;
                chr.needed = 3'(ones);
                chr.seen   = 3'd1;
            end
        end else begin
            fail_char();
        end
    endfunction

    // A trail byte is judged by the selector in force when it arrives.
    function automatic void continue_char(logic [7:0] b);
        bit ok;
        case (enc_sel)
            tesv_pkg::ENC_GBK:  ok = gbk_pair_ok(chr.lead, b);
            tesv_pkg::ENC_UTF8: ok = (b[7:6] == 2'b10);
            default:            ok = 1'b0;
        endcase
        if (!ok) begin
            fail_char();
        end else begin
            chr.seen = chr.seen + 3'd1;
            if (chr.seen >= chr.needed) accept_char(chr.needed, chr.lead);
        end
    endfunction

    // Update the predictor with one accepted beat; the end of a stream yields a report.
    function automatic void predict_beat(logic [7:0] b, logic eos);
        tesv_pkg::t_result rep;
        if (!chr.stopped) begin
            checked_beats++;
            if (chr.needed == 0) open_char(b);
            else continue_char(b);
        end
        if (eos) begin
            if (!chr.stopped && chr.needed != 0) fail_char();
            rep.passed = !chr.stopped;
            rep.line   = line_cnt;
            rep.col    = col_cnt;
            rep.offset = byte_offs;
            pending_reports.push_back(rep);
            reports_made++;
            clear_stream();
        end
    endfunction

    // Append one well-formed character for the current settings.
    function automatic void add_random_char();
        int         n;
        logic [7:0] pre;
        logic [7:0] mask;
        logic [7:0] lead;
        logic [7:0] trail;
        if (enc_sel == tesv_pkg::ENC_GBK && $urandom_range(99) >= 30) begin
            case ($urandom_range(4))
                0: begin
                    lead  = 8'($urandom_range(8'hA9, 8'hA1));
                    trail = 8'($urandom_range(8'hFE, 8'hA1));
                end
                1: begin
                    lead  = 8'($urandom_range(8'hF7, 8'hB0));
                    trail = 8'($urandom_range(8'hFE, 8'hA1));
                end
                2: begin
                    lead  = 8'($urandom_range(8'hA0, 8'h81));
                    trail = 8'($urandom_range(8'hFE, 8'h40));
                end
                3: begin
                    lead  = 8'($urandom_range(8'hFE, 8'hAA));
                    trail = 8'($urandom_range(8'hA0, 8'h40));
                end
                default: begin
                    lead  = 8'($urandom_range(8'hA9, 8'hA8));
                    trail = 8'($urandom_range(8'hA0, 8'h40));
                end
            endcase
            if (trail == 8'h7F) trail = 8'h80;
            stream_bytes.push_back(lead);
            stream_bytes.push_back(trail);
        end else if (enc_sel == tesv_pkg::ENC_UTF8 && $urandom_range(99) >= 35) begin
            n    = three_only ? 3 : $urandom_range(6, 2);
            pre  = 8'hFF << (8 - n);
            mask = 8'hFF >> (n + 1);
            stream_bytes.push_back(pre | (8'($urandom) & mask));
            repeat (n - 1) stream_bytes.push_back(8'h80 | (8'($urandom) & 8'h3F));
        end else if ($urandom_range(7) == 0) begin
            stream_bytes.push_back(tesv_pkg::NEWLINE_CHAR);
        end else begin
            stream_bytes.push_back(8'($urandom_range(8'h7F)));
        end
    endfunction

    // Drive one byte beat, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic eos);
        @(negedge clk);
        while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid         = 1'b1;
        byte_ch.data_byte     = b;
        byte_ch.end_of_stream = eos;
        do @(posedge clk); while (!byte_ch.ready);
        sent_beats++;
        predict_beat(b, eos);
    endtask

    // Send the staged bytes as one stream, marking the last one.
    task automatic send_stream();
        foreach (stream_bytes[i]) send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // Stop sending, wait for every pending report and let the pipeline settle.
    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        if (idx == tesv_pkg::CFG_IDX_ENCODING) enc_sel = value;
        else three_only = value[0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Default settings: UTF-8 limited to 3-byte characters.
    task automatic test_utf8_three_byte_only();
        stream_bytes = '{8'h00, tesv_pkg::NEWLINE_CHAR, 8'hE4, 8'hB8, 8'hAD};
        send_stream();
        // Truncated character at the end of the stream.
        stream_bytes = '{8'hE4, 8'hB8};
        send_stream();
        // A 2-byte lead is refused and the byte after it is ignored.
        stream_bytes = '{8'hC3, 8'hA9};
        send_stream();
    endtask

    task automatic test_utf8_all_lengths();
        wait_idle();
        write_reg(tesv_pkg::CFG_IDX_THREE_ONLY, 2'd0);
        stream_bytes = '{8'hC2, 8'h80, 8'hFD, 8'hBF, 8'h80, 8'h80, 8'h80, 8'h80};
        send_stream();
        // Seven leading ones is too long.
        stream_bytes = '{8'hFE};
        send_stream();
    endtask

    task automatic test_gbk_pairs();
        wait_idle();
        write_reg(tesv_pkg::CFG_IDX_ENCODING, tesv_pkg::ENC_GBK);
        // An invalid lead is held and rejected together with its trail byte.
        stream_bytes = '{8'hB0, 8'hA1, 8'h81, 8'h40, 8'hFF, 8'h41};
        send_stream();
        stream_bytes = '{8'hFF};
        send_stream();
    endtask

    // Selector changes while a character is open judge the trail bytes by the new setting.
    task automatic test_midstream_config();
        send_byte(8'hB0, 1'b0);
        wait_idle();
        write_reg(tesv_pkg::CFG_IDX_ENCODING, tesv_pkg::ENC_UTF8);
        send_byte(8'hA1, 1'b0);
        send_byte(8'hE4, 1'b0);
        wait_idle();
        write_reg(tesv_pkg::CFG_IDX_ENCODING, tesv_pkg::ENC_ASCII);
        send_byte(8'h80, 1'b1);
    endtask

    task automatic test_ascii_selectors();
        stream_bytes = '{8'h7F, 8'h80};
        send_stream();
        wait_idle();
        write_reg(tesv_pkg::CFG_IDX_ENCODING, ENC_SPARE);
        stream_bytes = '{8'h41, 8'hFF};
        send_stream();
    endtask

    // Random streams of mostly well-formed characters with noise bytes and cut-off ends.
    task automatic test_random_streams();
        int unsigned stream_no;
        int          len;
        int          r;
        stream_no = 0;
        while (sent_beats < BEAT_TARGET || reports_made < REPORT_TARGET) begin
            steady_mode = (stream_no >= 12 && stream_no < 22);
            if (stream_no % 3 == 0) begin
                wait_idle();
                r = $urandom_range(9);
                write_reg(tesv_pkg::CFG_IDX_ENCODING,
                          r < 2 ? tesv_pkg::ENC_ASCII : r < 5 ? tesv_pkg::ENC_GBK :
                          r < 9 ? tesv_pkg::ENC_UTF8 : ENC_SPARE);
                write_reg(tesv_pkg::CFG_IDX_THREE_ONLY, 2'($urandom_range(3)));
            end
            len = $urandom_range(24, 1);
            stream_bytes.delete();
            while (stream_bytes.size() < len) begin
                if ($urandom_range(99) < 10) stream_bytes.push_back(8'($urandom));
                else add_random_char();
            end
            if (stream_bytes.size() > 1 && $urandom_range(9) == 0)
                void'(stream_bytes.pop_back());
            send_stream();
            stream_no++;
        end
        steady_mode = 1'b0;
    endtask

    // The result side stalls at random unless in a steady stretch.
    always @(negedge clk) begin
        report_ch.ready = steady_mode || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each report beat with the oldest prediction.
    always @(posedge clk) begin : check_reports
        tesv_pkg::t_result want;
        if (rst_n && report_ch.valid && report_ch.ready) begin
            reports_seen++;
            if (report_ch.passed) reports_clean++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("report %0d arrived with nothing pending", reports_seen);
            end else begin
                want = pending_reports.pop_front();
                if (report_ch.passed !== want.passed ||
                    report_ch.stop_line !== want.line[tesv_pkg::OUT_WIDTH-1:0] ||
                    report_ch.stop_col !== want.col[tesv_pkg::OUT_WIDTH-1:0] ||
                    report_ch.stop_offset !== want.offset[tesv_pkg::OUT_WIDTH-1:0]) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("report %0d: expected passed=%0b line=%0d col=%0d off=%0d, %s",
                                 reports_seen, want.passed,
                                 want.line[tesv_pkg::OUT_WIDTH-1:0],
                                 want.col[tesv_pkg::OUT_WIDTH-1:0],
                                 want.offset[tesv_pkg::OUT_WIDTH-1:0],
                                 $sformatf("got passed=%0b line=%0d col=%0d off=%0d",
                                           report_ch.passed, report_ch.stop_line,
                                           report_ch.stop_col, report_ch.stop_offset));
                end
            end
        end
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    always @(posedge clk) begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (report_ch.valid && report_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = tesv_pkg::CFG_IDX_ENCODING;
        cfg_data              = tesv_pkg::ENC_ASCII;
        byte_ch.valid         = 1'b0;
        byte_ch.data_byte     = 8'h00;
        byte_ch.end_of_stream = 1'b0;
        enc_sel               = tesv_pkg::ENC_UTF8;
        three_only            = 1'b1;
        clear_stream();
        sent_beats            = 0;
        checked_beats         = 0;
        reports_made          = 0;
        steady_mode           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_utf8_three_byte_only();
        test_utf8_all_lengths();
        test_gbk_pairs();
        test_midstream_config();
        test_ascii_selectors();
        test_random_streams();

        wait_idle();

        $display("Sent %0d byte beats, %0d of them live, in %0d streams (%0d clean, %0d stopped).",
                 sent_beats, checked_beats, reports_seen, reports_clean,
                 reports_seen - reports_clean);
        $display("Settings covered ASCII, GBK, UTF-8 both ways and the spare selector; %0d bad.",
                 mismatches);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/tesv_pkg.sv
rtl/tesv_byte_if.sv
rtl/tesv_char_check.sv
rtl/tesv_tracker.sv
rtl/text_encoding_stream_validator.sv
bench/tb.sv
